@@ design/vgle_pkg.sv @@
// ----------------------------------------------------------------------------
// vgle_pkg
// Shared types, register codes and reset values for the vector glyph line
// endpoint pipeline.
// ----------------------------------------------------------------------------
package vgle_pkg;

  // field widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned LenW   = 31;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned SumW   = 64;
  localparam int unsigned NumW   = CoordW + LenW;   // mag * target
  localparam int unsigned AddrW  = 4;

  // register codes (word index inside the register block)
  typedef enum logic [1:0] {
    CfgMinLen = 2'd0,
    CfgMaxLen = 2'd1,
    CfgScale  = 2'd2,
    CfgAttach = 2'd3
  } cfg_idx_e;

  // attach modes
  localparam logic [ModeW-1:0] AttachStart = 2'd0;
  localparam logic [ModeW-1:0] AttachMid   = 2'd1;
  localparam logic [ModeW-1:0] AttachEnd   = 2'd2;

  // reset values
  localparam logic [LenW-1:0]   MinLenRst = '0;
  localparam logic [LenW-1:0]   MaxLenRst = '1;
  localparam logic [LenW-1:0]   ScaleRst  = 31'h0001_0000;
  localparam logic [ModeW-1:0]  AttachRst = AttachStart;

  // sideband carried through the square root
  typedef struct packed {
    logic [2:0][CoordW-1:0] pos;
    logic [2:0]             neg;
    logic [2:0][CoordW-1:0] mag;
    logic                   clamp;
    logic [LenW-1:0]        target;
  } sqrt_sb_t;

  // sideband carried through the divider
  typedef struct packed {
    logic [2:0][CoordW-1:0] pos;
    logic [2:0]             neg;
    logic [2:0][CoordW-1:0] mag;
    logic                   clamp;
  } div_sb_t;

endpackage

@@ design/vgle_sqrt.sv @@
// ----------------------------------------------------------------------------
// vgle_sqrt
// Pipelined integer square root of a 64-bit radicand, one result bit per
// stage, with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module vgle_sqrt import vgle_pkg::*; #(
  parameter int unsigned SbW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SumW-1:0]   rad_i,
  input  logic [SbW-1:0]    sb_i,
  output logic              valid_o,
  output logic [CoordW-1:0] root_o,
  output logic [SbW-1:0]    sb_o
);

  localparam int unsigned Steps = SumW / 2;

  logic [Steps-1:0] vld_q;
  logic [SumW-1:0]  s_q  [Steps];
  logic [SumW-1:0]  r_q  [Steps];
  logic [SbW-1:0]   sb_q [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam logic [SumW-1:0] Bit = SumW'(1) << (SumW - 2 - 2 * i);
    logic [SumW-1:0] s_in, r_in, trial, s_d, r_d;
    logic            v_in;
    logic [SbW-1:0]  sb_in;

    if (i == 0) begin : g_first
      assign s_in  = rad_i;
      assign r_in  = '0;
      assign v_in  = valid_i;
      assign sb_in = sb_i;
    end else begin : g_next
      assign s_in  = s_q[i-1];
      assign r_in  = r_q[i-1];
      assign v_in  = vld_q[i-1];
      assign sb_in = sb_q[i-1];
    end

    // one trial subtraction per stage
    assign trial = r_in + Bit;
    always_comb begin
      if (s_in >= trial) begin
        s_d = s_in - trial;
        r_d = (r_in >> 1) + Bit;
      end else begin
        s_d = s_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[i]  <= s_d;
        r_q[i]  <= r_d;
        sb_q[i] <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign root_o  = r_q[Steps-1][CoordW-1:0];
  assign sb_o    = sb_q[Steps-1];

endmodule

@@ design/vgle_div.sv @@
// ----------------------------------------------------------------------------
// vgle_div
// Three-lane pipelined restoring divider with a shared divisor. Quotients
// saturate to all ones when they would not fit in 32 bits.
// ----------------------------------------------------------------------------
module vgle_div import vgle_pkg::*; #(
  parameter int unsigned SbW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [2:0][NumW-1:0]   num_i,
  input  logic [CoordW-1:0]      den_i,
  input  logic [SbW-1:0]         sb_i,
  output logic                   valid_o,
  output logic [2:0][CoordW-1:0] quo_o,
  output logic [SbW-1:0]         sb_o
);

  localparam int unsigned Steps = CoordW;
  localparam int unsigned AccW  = 2 * CoordW;

  logic [Steps-1:0]         vld_q;
  logic [2:0][AccW-1:0]     acc_q [Steps];
  logic [2:0]               sat_q [Steps];
  logic [CoordW-1:0]        den_q [Steps];
  logic [SbW-1:0]           sb_q  [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [2:0][AccW-1:0] acc_in, acc_d;
    logic [2:0]           sat_in;
    logic [CoordW-1:0]    den_in;
    logic                 v_in;
    logic [SbW-1:0]       sb_in;

    if (i == 0) begin : g_first
      // high part of the dividend must stay below the divisor
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign acc_in[k] = AccW'(num_i[k]);
        assign sat_in[k] = {1'b0, num_i[k][NumW-1:CoordW]} >= den_i;
      end
      assign den_in = den_i;
      assign v_in   = valid_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign acc_in = acc_q[i-1];
      assign sat_in = sat_q[i-1];
      assign den_in = den_q[i-1];
      assign v_in   = vld_q[i-1];
      assign sb_in  = sb_q[i-1];
    end

    // one quotient bit per lane per stage
    for (genvar k = 0; k < 3; k++) begin : g_bit
      logic [CoordW:0] t, r;
      logic            qb;
      assign t  = acc_in[k][AccW-1:CoordW-1];
      assign qb = t >= {1'b0, den_in};
      assign r  = qb ? t - {1'b0, den_in} : t;
      assign acc_d[k] = {r[CoordW-1:0], acc_in[k][CoordW-2:0], qb};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[i] <= acc_d;
        sat_q[i] <= sat_in;
        den_q[i] <= den_in;
        sb_q[i]  <= sb_in;
      end
    end
  end

  // saturate oversized quotients
  for (genvar k = 0; k < 3; k++) begin : g_out
    assign quo_o[k] = sat_q[Steps-1][k] ? '1 : acc_q[Steps-1][k][CoordW-1:0];
  end

  assign valid_o = vld_q[Steps-1];
  assign sb_o    = sb_q[Steps-1];

endmodule

@@ design/vgle_out.sv @@
// ----------------------------------------------------------------------------
// vgle_out
// Output register with a skid entry; the pipeline advances while the skid
// entry is empty.
// ----------------------------------------------------------------------------
module vgle_out #(
  parameter int unsigned DataW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             en_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DataW-1:0] data_o
);

  logic             out_vld_q, skid_vld_q;
  logic [DataW-1:0] out_q, skid_q;

  assign en_o    = !skid_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

  // output and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || ready_i) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || ready_i) begin
      out_q <= skid_vld_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

endmodule

@@ design/vector_glyph_line_endpoints.sv @@
// ----------------------------------------------------------------------------
// vector_glyph_line_endpoints
// Clamps a vector's length, scales it and gives the glyph line endpoints.
// ----------------------------------------------------------------------------
// The block takes one point and vector per cycle while in_ready_o is high and
// gives one pair of line endpoints per item, in order. The pipeline holds the
// 32-stage square root and the 32-stage divider, each resolving one bit per
// stage, plus magnitude, squaring, sum, compare, dividend, scaling, rounding
// and saturation stages and the output register. A skid entry behind it lets
// the pipeline keep accepting while one result waits; with both full the input
// side stalls. Configuration goes through the APB port and is to be changed
// by the user only while no item is in flight; the block does not enforce it.
module vector_glyph_line_endpoints import vgle_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [CoordW-1:0] pos_z_i,
  input  logic signed [CoordW-1:0] vec_x_i,
  input  logic signed [CoordW-1:0] vec_y_i,
  input  logic signed [CoordW-1:0] vec_z_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] start_x_o,
  output logic signed [CoordW-1:0] start_y_o,
  output logic signed [CoordW-1:0] start_z_o,
  output logic signed [CoordW-1:0] end_x_o,
  output logic signed [CoordW-1:0] end_y_o,
  output logic signed [CoordW-1:0] end_z_o
);

  localparam int unsigned SqSbW  = $bits(sqrt_sb_t);
  localparam int unsigned DivSbW = $bits(div_sb_t);
  localparam int unsigned SqW    = 2 * LenW;
  localparam int unsigned ProdW  = CoordW + LenW;
  localparam int unsigned WW     = ProdW - 16;
  localparam int unsigned HW     = ProdW - 17;
  localparam int unsigned ExtW   = WW + 2;
  localparam logic [SqW-1:0] MaxSqRst = SqW'({{LenW{1'b0}}, MaxLenRst} *
                                             {{LenW{1'b0}}, MaxLenRst});

  logic en;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [LenW-1:0]  min_q, max_q, scale_q;
  logic [ModeW-1:0] attach_q;
  logic [SqW-1:0]   min_sq_q, max_sq_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= MinLenRst;
      max_q    <= MaxLenRst;
      scale_q  <= ScaleRst;
      attach_q <= AttachRst;
      min_sq_q <= '0;
      max_sq_q <= MaxSqRst;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx_e'(paddr[3:2]))
          CfgMinLen: min_q    <= pwdata[LenW-1:0];
          CfgMaxLen: max_q    <= pwdata[LenW-1:0];
          CfgScale:  scale_q  <= pwdata[LenW-1:0];
          CfgAttach: attach_q <= pwdata[ModeW-1:0];
          default:   ;
        endcase
      end
      min_sq_q <= {{LenW{1'b0}}, min_q} * {{LenW{1'b0}}, min_q};
      max_sq_q <= {{LenW{1'b0}}, max_q} * {{LenW{1'b0}}, max_q};
    end
  end

  // register read
  always_comb begin
    case (cfg_idx_e'(paddr[3:2]))
      CfgMinLen: prdata = 32'(min_q);
      CfgMaxLen: prdata = 32'(max_q);
      CfgScale:  prdata = 32'(scale_q);
      CfgAttach: prdata = 32'(attach_q);
      default:   prdata = '0;
    endcase
  end

  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // stage 1: magnitudes and signs
  // --------------------------------------------------------------------------
  logic [2:0][CoordW-1:0] vec, pos;
  logic [2:0][CoordW-1:0] s1_pos_q, s1_mag_q;
  logic [2:0]             s1_neg_q;
  logic                   s1_vld_q;

  assign vec = {vec_z_i, vec_y_i, vec_x_i};
  assign pos = {pos_z_i, pos_y_i, pos_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pos_q <= pos;
      for (int k = 0; k < 3; k++) begin
        s1_neg_q[k] <= vec[k][CoordW-1];
        s1_mag_q[k] <= vec[k][CoordW-1] ? ~vec[k] + CoordW'(1) : vec[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: squares
  // --------------------------------------------------------------------------
  logic [2:0][SumW-1:0]   s2_sq_q;
  logic [2:0][CoordW-1:0] s2_pos_q, s2_mag_q;
  logic [2:0]             s2_neg_q;
  logic                   s2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pos_q <= s1_pos_q;
      s2_mag_q <= s1_mag_q;
      s2_neg_q <= s1_neg_q;
      for (int k = 0; k < 3; k++) begin
        s2_sq_q[k] <= {32'd0, s1_mag_q[k]} * {32'd0, s1_mag_q[k]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: sum of squares
  // --------------------------------------------------------------------------
  logic [SumW-1:0]        s3_sum_q;
  logic                   s3_nz_q;
  logic [2:0][CoordW-1:0] s3_pos_q, s3_mag_q;
  logic [2:0]             s3_neg_q;
  logic                   s3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sum_q <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
      s3_nz_q  <= |s2_mag_q;
      s3_pos_q <= s2_pos_q;
      s3_mag_q <= s2_mag_q;
      s3_neg_q <= s2_neg_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: length clamp decision
  // --------------------------------------------------------------------------
  sqrt_sb_t        s4_sb_q;
  logic [SumW-1:0] s4_sum_q;
  logic            s4_vld_q;
  logic            is_short, is_long;

  assign is_short = s3_nz_q && (s3_sum_q < SumW'(min_sq_q));
  assign is_long  = s3_sum_q > SumW'(max_sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_sum_q         <= s3_sum_q;
      s4_sb_q.pos      <= s3_pos_q;
      s4_sb_q.neg      <= s3_neg_q;
      s4_sb_q.mag      <= s3_mag_q;
      s4_sb_q.clamp    <= is_short || is_long;
      s4_sb_q.target   <= is_short ? min_q : max_q;
    end
  end

  // --------------------------------------------------------------------------
  // vector length
  // --------------------------------------------------------------------------
  logic              sq_vld;
  logic [CoordW-1:0] sq_root;
  logic [SqSbW-1:0]  sq_sb_raw;
  sqrt_sb_t          sq_sb;

  vgle_sqrt #(
    .SbW (SqSbW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_vld_q),
    .rad_i   (s4_sum_q),
    .sb_i    (s4_sb_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .sb_o    (sq_sb_raw)
  );

  assign sq_sb = sqrt_sb_t'(sq_sb_raw);

  // --------------------------------------------------------------------------
  // dividend: magnitude times target plus half the length
  // --------------------------------------------------------------------------
  logic [CoordW-1:0]      len1;
  logic [2:0][NumW-1:0]   sm_num_q;
  logic [CoordW-1:0]      sm_len_q;
  div_sb_t                sm_sb_q;
  logic                   sm_vld_q;

  assign len1 = (sq_root == '0) ? CoordW'(1) : sq_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_vld_q <= 1'b0;
    end else if (en) begin
      sm_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sm_num_q[k] <= {{LenW{1'b0}}, sq_sb.mag[k]} * {{CoordW{1'b0}}, sq_sb.target}
                       + NumW'(len1 >> 1);
      end
      sm_len_q      <= len1;
      sm_sb_q.pos   <= sq_sb.pos;
      sm_sb_q.neg   <= sq_sb.neg;
      sm_sb_q.mag   <= sq_sb.mag;
      sm_sb_q.clamp <= sq_sb.clamp;
    end
  end

  // --------------------------------------------------------------------------
  // rescale by target over length
  // --------------------------------------------------------------------------
  logic                   dv_vld;
  logic [2:0][CoordW-1:0] dv_quo;
  logic [DivSbW-1:0]      dv_sb_raw;
  div_sb_t                dv_sb;

  vgle_div #(
    .SbW (DivSbW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sm_vld_q),
    .num_i   (sm_num_q),
    .den_i   (sm_len_q),
    .sb_i    (sm_sb_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .sb_o    (dv_sb_raw)
  );

  assign dv_sb = div_sb_t'(dv_sb_raw);

  // --------------------------------------------------------------------------
  // scale multiply
  // --------------------------------------------------------------------------
  logic [2:0][ProdW-1:0]  sc_prod_q;
  logic [2:0][CoordW-1:0] sc_pos_q;
  logic [2:0]             sc_neg_q;
  logic                   sc_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
    end else if (en) begin
      sc_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sc_prod_q[k] <= {{LenW{1'b0}}, (dv_sb.clamp ? dv_quo[k] : dv_sb.mag[k])}
                        * {{CoordW{1'b0}}, scale_q};
      end
      sc_pos_q <= dv_sb.pos;
      sc_neg_q <= dv_sb.neg;
    end
  end

  // --------------------------------------------------------------------------
  // rounded full and half offsets
  // --------------------------------------------------------------------------
  logic [2:0][WW-1:0]     rd_w_q;
  logic [2:0][HW-1:0]     rd_h_q;
  logic [2:0][CoordW-1:0] rd_pos_q;
  logic [2:0]             rd_neg_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (en) begin
      rd_vld_q <= sc_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rd_w_q[k] <= WW'(({1'b0, sc_prod_q[k]} + (ProdW + 1)'(32'h8000)) >> 16);
        rd_h_q[k] <= HW'(({1'b0, sc_prod_q[k]} + (ProdW + 1)'(32'h1_0000)) >> 17);
      end
      rd_pos_q <= sc_pos_q;
      rd_neg_q <= sc_neg_q;
    end
  end

  // --------------------------------------------------------------------------
  // endpoints with saturation
  // --------------------------------------------------------------------------
  function automatic logic [CoordW-1:0] sat32(input logic signed [ExtW-1:0] v);
    logic signed [ExtW-1:0] hi, lo;
    hi = ExtW'(32'sh7FFF_FFFF);
    lo = -ExtW'(33'sh0_8000_0000);
    if (v > hi) begin
      return 32'h7FFF_FFFF;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end
    return v[CoordW-1:0];
  endfunction

  logic [5:0][CoordW-1:0] ep_data_q;
  logic                   ep_vld_q;
  logic [5:0][CoordW-1:0] ep_data_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [ExtW-1:0] p, w, h, st, fin;
      p  = ExtW'(signed'(rd_pos_q[k]));
      w  = rd_neg_q[k] ? -signed'(ExtW'(rd_w_q[k])) : signed'(ExtW'(rd_w_q[k]));
      h  = rd_neg_q[k] ? -signed'(ExtW'(rd_h_q[k])) : signed'(ExtW'(rd_h_q[k]));
      case (attach_q)
        AttachMid: begin
          st  = p - h;
          fin = p + h;
        end
        AttachEnd: begin
          st  = p - w;
          fin = p;
        end
        default: begin
          st  = p;
          fin = p + w;
        end
      endcase
      ep_data_d[k]     = sat32(st);
      ep_data_d[3 + k] = sat32(fin);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep_vld_q <= 1'b0;
    end else if (en) begin
      ep_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ep_data_q <= ep_data_d;
    end
  end

  // --------------------------------------------------------------------------
  // output register and skid entry
  // --------------------------------------------------------------------------
  logic [5:0][CoordW-1:0] out_data;

  vgle_out #(
    .DataW (6 * CoordW)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && ep_vld_q),
    .data_i  (ep_data_q),
    .en_o    (en),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign start_x_o = out_data[0];
  assign start_y_o = out_data[1];
  assign start_z_o = out_data[2];
  assign end_x_o   = out_data[3];
  assign end_y_o   = out_data[4];
  assign end_z_o   = out_data[5];

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a stall of the input side only happens with a result waiting
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result on the output");

  // the last pipeline stage holds while stalled
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(ep_vld_q) && $stable(ep_data_q))
    else $error("pipeline moved during a stall");

  // the squared minimum follows the register in the cycle after
  a_min_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(min_q) |=> min_sq_q == {{LenW{1'b0}}, $past(min_q)} *
                                   {{LenW{1'b0}}, $past(min_q)})
    else $error("squared minimum out of step with register");

endmodule
